// ----- hw/rtl/gis_pkg.sv -----
// gis_pkg: shared widths and defaults for the greedy interval selection block
// no dependencies; imported by the top level and its checker
`default_nettype none

package gis_pkg;

    localparam int MAX_INTERVALS_DEF = 1024;
    localparam int TIME_BITS_DEF     = 11;

    // day length register and result count widths are fixed
    localparam int DAY_BITS   = 11;
    localparam int COUNT_BITS = 11;

    localparam logic [DAY_BITS-1:0] DAY_RESET = 11'd1440;

endpackage

`default_nettype wire

// ----- hw/rtl/gis_ram.sv -----
// gis_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module gis_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/greedy_interval_selection_top.sv -----
// greedy_interval_selection_top: loads intervals, then counts a greedy earliest-finish pick
// depends on gis_pkg and gis_ram
// load: one interval transfer per cycle while not stalled, stored in the ram until full
// scan: after the marked last interval, each round walks all N loaded entries through
//   the single ram read port, (picks + 1) rounds in all; the result is published at
//   the end of the round that finds no candidate
// reset (synchronous, active low) empties the set, drops any pending result and sets
//   day_length to 1440; ram contents are not cleared
`default_nettype none

module greedy_interval_selection_top #(
    parameter int MAX_INTERVALS = gis_pkg::MAX_INTERVALS_DEF,
    parameter int TIME_BITS     = gis_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [gis_pkg::DAY_BITS-1:0]  i_cfg_data,
    // interval input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [TIME_BITS-1:0]          i_start_time,
    input  wire logic [TIME_BITS-1:0]          i_end_time,
    input  wire logic                          i_last_interval,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [gis_pkg::COUNT_BITS-1:0]     o_selected_count,
    output logic                               o_overflowed
);

    import gis_pkg::*;

    localparam int AW    = $clog2(MAX_INTERVALS);
    localparam int CW    = AW + 1;                  // holds 0..MAX_INTERVALS
    localparam int CMP_W = (TIME_BITS > DAY_BITS) ? TIME_BITS : DAY_BITS;
    localparam int RAM_W = 2 * TIME_BITS;

    typedef enum logic {
        ST_LOAD,
        ST_SCAN
    } t_state;

    t_state                r_state;
    logic [DAY_BITS-1:0]   r_day;
    logic [CW-1:0]         r_count;      // entries loaded in the current set
    logic                  r_ovf;        // set dropped an interval
    logic [CW-1:0]         r_num;        // entries to scan
    logic                  r_res_ovf;
    logic [CW-1:0]         r_idx;        // next read address
    logic                  r_pipe_vld;   // ram read data valid this cycle
    logic [CMP_W-1:0]      r_best;
    logic                  r_found;
    logic [TIME_BITS-1:0]  r_last;       // last chosen end
    logic                  r_first;
    logic [COUNT_BITS-1:0] r_sel;
    logic                  r_out_valid;

    logic                  in_xfer;
    logic                  full;
    logic                  ram_we;
    logic                  issue;
    logic [RAM_W-1:0]      ram_rdata;
    logic [TIME_BITS-1:0]  rd_start;
    logic [TIME_BITS-1:0]  rd_end;
    logic                  hit;
    logic                  round_end;

    // a new set may load while a result waits; only a last interval has to wait
    // for the result slot, since it starts a scan that ends in a new result
    assign o_stall  = (r_state == ST_SCAN) || (i_last_interval && r_out_valid && i_stall);
    assign in_xfer  = i_valid && !o_stall;
    assign full     = (r_count == CW'(MAX_INTERVALS));
    assign ram_we   = in_xfer && !full;

    // loading and scanning never overlap, so the ram needs no forwarding
    assign issue    = (r_state == ST_SCAN) && (r_idx < r_num);

    gis_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_INTERVALS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({i_start_time, i_end_time}),
        .i_re   (issue),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign rd_start = ram_rdata[RAM_W-1:TIME_BITS];
    assign rd_end   = ram_rdata[TIME_BITS-1:0];

    // candidate test: starts at or after the last end, ends earliest below the bound,
    // and after the first pick ends strictly later than the last end
    assign hit = r_pipe_vld && (rd_start >= r_last) && (CMP_W'(rd_end) < r_best)
              && (r_first || (rd_end > r_last));

    // all reads of this round issued and returned
    assign round_end = (r_state == ST_SCAN) && !r_pipe_vld && (r_idx == r_num);

    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_day       <= DAY_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pipe_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_day <= i_cfg_data;
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    r_pipe_vld <= 1'b0;
                    if (in_xfer) begin
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                        if (i_last_interval) begin
                            // close the set and start the first round
                            r_num     <= full ? r_count : r_count + CW'(1);
                            r_res_ovf <= r_ovf || full;
                            r_count   <= '0;
                            r_ovf     <= 1'b0;
                            r_idx     <= '0;
                            r_best    <= CMP_W'(r_day);
                            r_found   <= 1'b0;
                            r_last    <= '0;
                            r_first   <= 1'b1;
                            r_sel     <= '0;
                            r_state   <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_pipe_vld <= issue;
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (hit) begin
                        r_best  <= CMP_W'(rd_end);
                        r_found <= 1'b1;
                    end
                    if (round_end) begin
                        if (r_found) begin
                            // take the pick and run another round
                            r_last  <= r_best[TIME_BITS-1:0];
                            r_sel   <= r_sel + COUNT_BITS'(1);
                            r_first <= 1'b0;
                            r_best  <= CMP_W'(r_day);
                            r_found <= 1'b0;
                            r_idx   <= '0;
                        end else begin
                            // no candidate left: publish the count
                            o_selected_count <= r_sel;
                            o_overflowed     <= r_res_ovf;
                            r_out_valid      <= 1'b1;
                            r_state          <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gis_chk.sv -----
// gis_chk: port-level checks for greedy_interval_selection_top, attached by bind
// depends on gis_pkg
`default_nettype none

module gis_chk #(
    parameter int TIME_BITS = gis_pkg::TIME_BITS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic [TIME_BITS-1:0]          i_start_time,
    input wire logic [TIME_BITS-1:0]          i_end_time,
    input wire logic                          i_last_interval,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [gis_pkg::COUNT_BITS-1:0] o_selected_count,
    input wire logic                          o_overflowed
);

    import gis_pkg::*;

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_selected_count)
                                  && $stable(o_overflowed)))
        else $error("stalled result changed");

    // a stalled interval holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_start_time)
                                  && $stable(i_end_time) && $stable(i_last_interval)))
        else $error("stalled interval changed");

    // the last interval starts a scan, during which input is held off
    a_scan_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_interval) |=> (o_stall && !o_valid))
        else $error("no scan after last interval");

    // a result only appears at the end of a scan
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a scan");

endmodule

bind greedy_interval_selection_top gis_chk #(.TIME_BITS(TIME_BITS)) u_gis_chk (.*);

`default_nettype wire

// ----- tb/greedy_interval_selection_checker.sv -----
// greedy_interval_selection_checker: watches both channels and the day length port,
// predicts each set's greedy count and overflow flag and compares the results
// depends on gis_pkg
`timescale 1ns / 1ps

module greedy_interval_selection_checker #(
    parameter int MAX_INTERVALS = gis_pkg::MAX_INTERVALS_DEF,
    parameter int TIME_BITS     = gis_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gis_pkg::DAY_BITS-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [TIME_BITS-1:0]          i_start_time,
    input  logic [TIME_BITS-1:0]          i_end_time,
    input  logic                          i_last_interval,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [gis_pkg::COUNT_BITS-1:0] i_selected_count,
    input  logic                          i_overflowed,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [gis_pkg::COUNT_BITS-1:0] count;
        logic                           ovf;
    } t_pick_result;

    logic [TIME_BITS-1:0]        start_mem [MAX_INTERVALS];
    logic [TIME_BITS-1:0]        end_mem   [MAX_INTERVALS];
    int                          loaded;
    logic                        ovf_mark;
    logic [gis_pkg::DAY_BITS-1:0] day_len;
    t_pick_result                expected_picks [$];
    int                          fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        loaded       = 0;
        ovf_mark     = 1'b0;
        day_len      = gis_pkg::DAY_RESET;
    end

    // earliest finish first over the first n stored intervals
    function automatic logic [gis_pkg::COUNT_BITS-1:0] count_picks(input int n);
        logic [TIME_BITS-1:0] last_end;
        logic [TIME_BITS-1:0] best;
        bit first, found, done;
        int picks;
        last_end = '0;
        picks    = 0;
        first    = 1'b1;
        done     = 1'b0;
        while (!done) begin
            best  = day_len;
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (start_mem[i] >= last_end && end_mem[i] < best &&
                    (first || end_mem[i] > last_end)) begin
                    best  = end_mem[i];
                    found = 1'b1;
                end
            end
            if (found) begin
                last_end = best;
                picks++;
                first = 1'b0;
            end else begin
                done = 1'b1;
            end
        end
        return picks[gis_pkg::COUNT_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_pick_result want;
        if (!i_rst_n) begin
            loaded   = 0;
            ovf_mark = 1'b0;
            day_len  = gis_pkg::DAY_RESET;
            expected_picks.delete();
        end else begin
            if (i_cfg_we) begin
                day_len = i_cfg_data;
            end
            // result side
            if (i_out_valid && !i_out_stall) begin
                if (expected_picks.size() == 0) begin
                    $error("unexpected result: selected_count %0d overflowed %0d",
                           i_selected_count, i_overflowed);
                    fail_total++;
                end else begin
                    want = expected_picks.pop_front();
                    if (i_selected_count !== want.count) begin
                        $error("selected_count: expected %0d, actual %0d",
                               want.count, i_selected_count);
                        fail_total++;
                    end
                    if (i_overflowed !== want.ovf) begin
                        $error("overflowed: expected %0d, actual %0d",
                               want.ovf, i_overflowed);
                        fail_total++;
                    end
                end
            end
            // interval side
            if (i_in_valid && !i_in_stall) begin
                if (loaded < MAX_INTERVALS) begin
                    start_mem[loaded] = i_start_time;
                    end_mem[loaded]   = i_end_time;
                    loaded++;
                end else begin
                    ovf_mark = 1'b1;
                end
                if (i_last_interval) begin
                    want.count = count_picks(loaded);
                    want.ovf   = ovf_mark;
                    expected_picks.insert(expected_picks.size(), want);
                    loaded   = 0;
                    ovf_mark = 1'b0;
                end
            end
        end
        o_pending    <= expected_picks.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- tb/greedy_interval_selection_top_tb.sv -----
// greedy_interval_selection_top_tb: stimulus and verdict for the greedy interval block
// depends on gis_pkg, greedy_interval_selection_top and greedy_interval_selection_checker
`timescale 1ns / 1ps

module greedy_interval_selection_top_tb;

    localparam int MAXI = gis_pkg::MAX_INTERVALS_DEF;
    localparam int TB   = gis_pkg::TIME_BITS_DEF;
    localparam int DB   = gis_pkg::DAY_BITS;
    localparam int CB   = gis_pkg::COUNT_BITS;

    // worst case: a full store scanned once per pick, times several, plus stalls
    localparam int CYCLE_LIMIT = 6_000_000;
    // no work is left once the last result has been taken
    localparam int DRAIN_CYCLES = 32;
    localparam int GROUP_ITEMS  = 55;

    logic          i_clk           = 1'b0;
    logic          i_rst_n         = 1'b0;
    logic          i_cfg_we        = 1'b0;
    logic [DB-1:0] i_cfg_data      = '0;
    logic          i_valid         = 1'b0;
    logic          o_stall;
    logic [TB-1:0] i_start_time    = '0;
    logic [TB-1:0] i_end_time      = '0;
    logic          i_last_interval = 1'b0;
    logic          o_valid;
    logic          i_stall         = 1'b0;
    logic [CB-1:0] o_selected_count;
    logic          o_overflowed;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int day_now       = gis_pkg::DAY_RESET;
    int items_sent    = 0;
    int sets_sent     = 0;
    int days_written  = 0;

    greedy_interval_selection_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_start_time     (i_start_time),
        .i_end_time       (i_end_time),
        .i_last_interval  (i_last_interval),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_selected_count (o_selected_count),
        .o_overflowed     (o_overflowed)
    );

    greedy_interval_selection_checker #(
        .MAX_INTERVALS (MAXI),
        .TIME_BITS     (TB)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_start_time     (i_start_time),
        .i_end_time       (i_end_time),
        .i_last_interval  (i_last_interval),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_selected_count (o_selected_count),
        .i_overflowed     (o_overflowed),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver back-pressure, independent of o_valid
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one interval transfer, with a random idle gap in front of it
    task automatic send_interval(input logic [TB-1:0] s, input logic [TB-1:0] e,
                                 input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_start_time    <= s;
        i_end_time      <= e;
        i_last_interval <= last;
        @(posedge i_clk);
        // payload holds while the block stalls
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (last) sets_sent++;
    endtask

    // hold off the sender until every expected result has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // day length write, only with the block idle
    task automatic write_day(input int value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[DB-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        day_now = value;
        days_written++;
    endtask

    // one set of n intervals, the last one marked
    // clean sets mostly hold short, in-range intervals so the scan picks many
    task automatic send_random_set(input int n, input bit clean);
        int s, e, top_t, span;
        top_t = (day_now > 0) ? day_now - 1 : 0;
        for (int k = 0; k < n; k++) begin
            if (clean && $urandom_range(0, 9) != 0) begin
                s = $urandom_range(0, top_t);
                span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, top_t)
                                                   : $urandom_range(0, 40);
                e = (s + span > top_t) ? top_t : s + span;
                // zero-length and just-outside-the-day ends
                if ($urandom_range(0, 7) == 0) e = s;
                if ($urandom_range(0, 15) == 0) e = day_now;
            end else begin
                s = $urandom_range(0, 2047);
                e = $urandom_range(0, 2047);
            end
            send_interval(s[TB-1:0], e[TB-1:0], k == n - 1);
        end
    endtask

    initial begin
        int day_pick;
        int group_start;
        int ovf_items;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset day length 1440
        send_interval(11'd0, 11'd0, 1'b1);          // lone zero-length interval
        send_interval(11'd0, 11'd0, 1'b0);          // repeated zero-length, picked once
        send_interval(11'd0, 11'd0, 1'b0);
        send_interval(11'd0, 11'd5, 1'b1);
        send_interval(11'd2047, 11'd2047, 1'b1);    // end past the day
        send_interval(11'd100, 11'd50, 1'b0);       // end before start
        send_interval(11'd60, 11'd70, 1'b1);
        send_interval(11'd0, 11'd1439, 1'b0);       // last minute of the day
        send_interval(11'd1439, 11'd1439, 1'b1);

        write_day(2047);                            // widest day
        send_interval(11'd0, 11'd2046, 1'b0);
        send_interval(11'd2046, 11'd2047, 1'b0);
        send_interval(11'd0, 11'd2047, 1'b1);

        write_day(0);                               // zero day, nothing qualifies
        send_interval(11'd0, 11'd0, 1'b0);
        send_interval(11'd5, 11'd10, 1'b1);

        write_day(1);                               // only end zero qualifies
        send_interval(11'd0, 11'd0, 1'b0);
        send_interval(11'd0, 11'd1, 1'b1);

        // random part: three handshake modes, four day lengths each
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 55;
                end
                1: begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 12;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int g = 0; g < 4; g++) begin
                case (g)
                    0: day_pick = 2047;
                    1: day_pick = 1;
                    2: day_pick = gis_pkg::DAY_RESET;
                    default: day_pick = $urandom_range(2, 2046);
                endcase
                write_day(day_pick);
                group_start = items_sent;
                while (items_sent - group_start < GROUP_ITEMS) begin
                    send_random_set(($urandom_range(0, 9) == 0) ? $urandom_range(1, 64)
                                                                : $urandom_range(1, 16),
                                    $urandom_range(0, 4) != 0);
                    // now and then let the block run dry between sets
                    if ($urandom_range(0, 9) == 0) wait_drained();
                end
            end
        end

        // overfull set: the store fills and the tail, the marked one too, is dropped
        write_day(gis_pkg::DAY_RESET);
        ovf_items = MAXI + $urandom_range(1, 3);
        send_random_set(ovf_items, 1'b0);
        // a short set right after shows the overflow mark was cleared
        send_random_set(4, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d interval transfers in %0d sets, %0d day length writes,",
                 items_sent, sets_sent, days_written);
        $display("three handshake modes and one set past the store capacity");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
